// ===== hw/rtl/smmq_pkg.sv =====
// shared types and constants for the sorted min/max queue
// no dependencies; used by smmq_cell and sorted_minmax_queue_core
package smmq_pkg;

  localparam int SMMQ_CAPACITY = 16;
  localparam int DATA_W        = 32;
  localparam int COUNT_OUT_W   = 5;

  // operation codes carried in the low bits of s_tdata
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_MIN = 2'd1,
    OP_DEL_MAX = 2'd2,
    OP_CLEAR   = 2'd3
  } smmq_op_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                     insert_en;
    logic                     shift_en;
    logic signed [DATA_W-1:0] value;
  } smmq_cmd_t;

endpackage

// ===== hw/rtl/smmq_cell.sv =====
// one storage cell of the sorted chain: holds one entry, hands it to its neighbors
// depends on smmq_pkg
module smmq_cell
  import smmq_pkg::*;
(
  input  logic                     clk,
  input  smmq_cmd_t                cmd,
  input  logic                     occupied,
  input  logic                     left_gt,
  input  logic signed [DATA_W-1:0] left_entry,
  input  logic signed [DATA_W-1:0] right_entry,
  output logic                     gt,
  output logic signed [DATA_W-1:0] entry
);

  logic signed [DATA_W-1:0] entry_next;

  // a free cell acts as plus infinity so the insert lands at the first free place
  assign gt = !occupied || (entry > cmd.value);

  // insert: cells above the insert point take the left neighbor, the point takes the value
  always_comb begin
    entry_next = entry;
    if (cmd.insert_en) begin
      if (gt) begin
        entry_next = left_gt ? left_entry : cmd.value;
      end
    end else if (cmd.shift_en) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== hw/rtl/sorted_minmax_queue_core.sv =====
// top level of the sorted min/max queue: cell chain, count, result register
// depends on smmq_pkg and smmq_cell
//
// Bounded double-ended priority queue holding up to CAPACITY signed 32-bit
// values in ascending order in a chain of cells, one entry per cell. Each
// transfer on the slave side is one operation (insert, delete minimum,
// delete maximum, clear); every cell updates in the same cycle from its own
// entry and its neighbors, so an insert or a delete-minimum shift does not
// depend on fill. The result (minimum, maximum, count, empty, full, error)
// is registered from the updated state once the master side is free, and
// the queue takes one operation per cycle while the master side accepts.
// The maximum is picked from the cell at position count-1 by a one-hot
// select across the chain, which sets the result register path. Insert on
// a full queue and delete on an empty queue leave the state unchanged and
// set the error flag; minimum and maximum read 0 when the queue is empty.
module sorted_minmax_queue_core
  import smmq_pkg::*;
#(
  parameter int CAPACITY = SMMQ_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[1:0], value[33:2], zero pad[39:34]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // min_value[31:0], max_value[63:32], entry_count[68:64], is_empty[69],
  // is_full[70], op_error[71]
  output logic [71:0] m_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     op_err;
  logic                     op_err_next;
  logic                     pending;
  logic                     load;
  logic                     accept;
  smmq_op_t                 op;
  logic signed [DATA_W-1:0] in_value;
  logic                     is_full_now;
  logic                     is_empty_now;
  smmq_cmd_t                cmd;

  logic signed [DATA_W-1:0] entries [CAPACITY];
  logic                     gts     [CAPACITY];

  logic signed [DATA_W-1:0] min_sel;
  logic signed [DATA_W-1:0] max_sel;
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

  // input decode
  assign op           = smmq_op_t'(s_tdata[1:0]);
  assign in_value     = s_tdata[DATA_W+1:2];
  assign is_full_now  = (count == CNT_W'(CAPACITY));
  assign is_empty_now = (count == '0);

  // result register loads after an operation once the output is free; input waits only behind it
  assign load     = pending && (!m_tvalid || m_tready);
  assign s_tready = !pending || load;
  assign accept   = s_tvalid && s_tready;

  // command to the chain and next count
  always_comb begin
    cmd.insert_en = 1'b0;
    cmd.shift_en  = 1'b0;
    cmd.value     = in_value;
    count_next    = count;
    op_err_next   = 1'b0;
    case (op)
      OP_INSERT: begin
        if (is_full_now) begin
          op_err_next = 1'b1;
        end else begin
          cmd.insert_en = accept;
          count_next    = count + CNT_W'(1);
        end
      end
      OP_DEL_MIN: begin
        if (is_empty_now) begin
          op_err_next = 1'b1;
        end else begin
          cmd.shift_en = accept;
          count_next   = count - CNT_W'(1);
        end
      end
      OP_DEL_MAX: begin
        if (is_empty_now) begin
          op_err_next = 1'b1;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     left_gt;
    logic signed [DATA_W-1:0] left_entry;
    logic signed [DATA_W-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_entry = in_value;
    end else begin : g_mid
      assign left_gt    = gts[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    smmq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (CNT_W'(i) < count),
      .left_gt     (left_gt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .gt          (gts[i]),
      .entry       (entries[i])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      op_err  <= 1'b0;
      pending <= 1'b0;
    end else begin
      if (accept) begin
        count  <= count_next;
        op_err <= op_err_next;
      end
      pending <= accept || (pending && !load);
    end
  end

  // minimum from the first cell, maximum from the cell at count-1
  always_comb begin
    min_sel = is_empty_now ? '0 : entries[0];
    max_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i + 1) == count) begin
        max_sel = max_sel | entries[i];
      end
    end
  end

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {op_err, is_full_now, is_empty_now, count_ext[COUNT_OUT_W-1:0],
                  max_sel, min_sel};
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_INSERT && is_full_now |=> op_err && count == $past(count))
    else $error("insert on full queue changed state or missed error");

  a_empty_delete: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_DEL_MIN || op == OP_DEL_MAX) && is_empty_now
    |=> op_err && count == '0)
    else $error("delete on empty queue changed state or missed error");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_CLEAR |=> count == '0 && !op_err)
    else $error("clear did not empty the queue");

  for (genvar i = 0; i + 1 < CAPACITY; i++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      CNT_W'(i + 1) < count |-> entries[i] <= entries[i+1])
      else $error("stored entries out of order");
  end

endmodule
